FILE: rtl/core/xmpt_pkg.sv
`default_nettype none

package xmpt_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_ADDR_W = 3;
  localparam logic [WORD_W-1:0] SEED_WORD = 32'h1357_9BDF;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ACT_IDLE   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_WINDOW_BASE = 1'b0,
    REG_WINDOW_END  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    action_e           action;
    logic [WORD_W-1:0] mem_address;
    logic [WORD_W-1:0] wr_word;
    status_e           status;
    logic [WORD_W-1:0] fail_address;
    logic [WORD_W-1:0] expected_word;
    logic [WORD_W-1:0] actual_word;
  } result_t;

  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xmpt_skid.sv
`default_nettype none

module xmpt_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire xmpt_pkg::result_t in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      xmpt_pkg::result_t out_data_o
);
  import xmpt_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    out_free;
  logic    in_xfer;

  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;
  assign out_free    = !main_valid_q || !out_stall_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid entry first, input is stalled meanwhile
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_xfer) begin
        main_d       = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (in_xfer) begin
      // hold the waiting result, park the new one
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/xorshift_memory_pattern_test.sv
`default_nettype none

// Memory self-test sequencer with an xorshift32 pattern. A start transfer
// (opcode 0) checks base, size and word limit against the window registers
// and answers at once, either accepted or finished with status invalid. Each
// step transfer (opcode 1) then yields one memory write of the pattern, and
// after the write pass one read request per word; rd_word_i of a step carries
// the word for the read issued by the step before, and the test finishes with
// ok or with the failing address, expected and actual word. Every transfer gives
// exactly one result, which is registered: the step logic sits between the sequencer
// state and an output register, and a two-entry output buffer lets a new
// transfer in while a result waits downstream, so one transfer per cycle is
// sustained while the output is not stalled and no result is parked.
// ADDR_WIDTH sets the size of the address space that a test may span.
module xorshift_memory_pattern_test #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [xmpt_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,

  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [0:0]  opcode_i,
  input  wire logic [31:0] base_address_i,
  input  wire logic [31:0] byte_size_i,
  input  wire logic [31:0] word_limit_i,
  input  wire logic [31:0] rd_word_i,

  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  action_o,
  output      logic [31:0] mem_address_o,
  output      logic [31:0] wr_word_o,
  output      logic [1:0]  status_o,
  output      logic [31:0] fail_address_o,
  output      logic [31:0] expected_word_o,
  output      logic [31:0] actual_word_o
);
  import xmpt_pkg::*;

  localparam int unsigned IDX_W = ADDR_WIDTH - 1;
  localparam logic [WORD_W:0] AddrSpace = (WORD_W + 1)'(1) << ADDR_WIDTH;

  // configuration
  logic [WORD_W-1:0] win_base_q;
  logic [WORD_W-1:0] win_end_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_BASE: prdata = win_base_q;
      REG_WINDOW_END:  prdata = win_end_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_base_q <= '0;
      win_end_q  <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW_BASE: win_base_q <= pwdata;
        REG_WINDOW_END:  win_end_q  <= pwdata;
        default:         ;
      endcase
    end
  end

  // sequencer state
  phase_e                phase_q, phase_d;
  logic [IDX_W-1:0]      word_index_q, word_index_d;
  logic [IDX_W-1:0]      word_count_q, word_count_d;
  logic [ADDR_WIDTH-1:0] start_addr_q, start_addr_d;
  logic [WORD_W-1:0]     pattern_q, pattern_d;
  logic [WORD_W-1:0]     pend_exp_q, pend_exp_d;
  logic                  read_pend_q, read_pend_d;

  logic              in_xfer;
  logic              skid_stall;
  result_t           res;
  result_t           res_out;

  logic [WORD_W:0]     base_ext;
  logic [WORD_W:0]     end_ext;
  logic [WORD_W:0]     win_lim;
  logic                bad_args;
  logic [WORD_W-1:0]   size_words;
  logic [WORD_W-1:0]   words;
  logic [IDX_W-1:0]    idx_inc;
  logic [IDX_W-1:0]    idx_eff;
  logic [WORD_W-1:0]   next_pat;
  logic [WORD_W-1:0]   addr_cur;
  logic                finished;

  assign in_stall_o = skid_stall;
  assign in_xfer    = in_valid_i && !skid_stall;

  function automatic logic [WORD_W-1:0] word_addr(input logic [ADDR_WIDTH-1:0] base,
                                                  input logic [IDX_W-1:0] idx);
    logic [ADDR_WIDTH-1:0] a;
    a = base + {idx[ADDR_WIDTH-3:0], 2'b00};
    return WORD_W'(a);
  endfunction

  assign base_ext   = {1'b0, base_address_i};
  assign end_ext    = base_ext + {1'b0, byte_size_i};
  assign win_lim    = {1'b0, win_end_q} + (WORD_W + 1)'(1);
  assign bad_args   = (base_address_i < win_base_q) || (base_ext >= AddrSpace) ||
                      (base_address_i[1:0] != 2'b00) || (byte_size_i < WORD_W'(4)) ||
                      (word_limit_i == '0) || (end_ext > win_lim) ||
                      (end_ext > AddrSpace);
  assign size_words = byte_size_i >> 2;
  assign words      = (size_words > word_limit_i) ? word_limit_i : size_words;
  assign idx_inc    = word_index_q + IDX_W'(1);
  assign next_pat   = xorshift32(pattern_q);
  assign addr_cur   = word_addr(start_addr_q, word_index_q);

  always_comb begin
    phase_d      = phase_q;
    word_index_d = word_index_q;
    word_count_d = word_count_q;
    start_addr_d = start_addr_q;
    pattern_d    = pattern_q;
    pend_exp_d   = pend_exp_q;
    read_pend_d  = read_pend_q;
    res          = '0;
    res.action   = ACT_IDLE;
    res.status   = ST_OK;
    idx_eff      = word_index_q;
    finished     = 1'b0;

    if (in_xfer) begin
      if (opcode_e'(opcode_i) == OP_START) begin
        read_pend_d = 1'b0;
        pend_exp_d  = '0;
        if (bad_args) begin
          phase_d    = PH_IDLE;
          res.action = ACT_FINISH;
          res.status = ST_INVALID;
        end else begin
          start_addr_d = base_address_i[ADDR_WIDTH-1:0];
          word_count_d = words[IDX_W-1:0];
          word_index_d = '0;
          pattern_d    = SEED_WORD;
          phase_d      = PH_WRITE;
        end
      end else begin
        unique case (phase_q)
          PH_WRITE: begin
            pattern_d        = next_pat;
            res.action       = ACT_WRITE;
            res.mem_address  = addr_cur;
            res.wr_word      = next_pat;
            if (idx_inc >= word_count_q) begin
              // write pass done, rewind for the read pass
              phase_d      = PH_READ;
              word_index_d = '0;
              pattern_d    = SEED_WORD;
              read_pend_d  = 1'b0;
            end else begin
              word_index_d = idx_inc;
            end
          end
          PH_READ: begin
            if (read_pend_q) begin
              read_pend_d = 1'b0;
              if (rd_word_i != pend_exp_q) begin
                phase_d           = PH_IDLE;
                res.action        = ACT_FINISH;
                res.status        = ST_MISMATCH;
                res.fail_address  = addr_cur;
                res.expected_word = pend_exp_q;
                res.actual_word   = rd_word_i;
                finished          = 1'b1;
              end else begin
                idx_eff      = idx_inc;
                word_index_d = idx_inc;
                if (idx_inc >= word_count_q) begin
                  phase_d    = PH_IDLE;
                  res.action = ACT_FINISH;
                  finished   = 1'b1;
                end
              end
            end
            if (!finished) begin
              pend_exp_d      = next_pat;
              pattern_d       = next_pat;
              read_pend_d     = 1'b1;
              res.action      = ACT_READ;
              res.mem_address = word_addr(start_addr_q, idx_eff);
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      word_index_q <= '0;
      word_count_q <= '0;
      start_addr_q <= '0;
      pattern_q    <= SEED_WORD;
      pend_exp_q   <= '0;
      read_pend_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      word_index_q <= word_index_d;
      word_count_q <= word_count_d;
      start_addr_q <= start_addr_d;
      pattern_q    <= pattern_d;
      pend_exp_q   <= pend_exp_d;
      read_pend_q  <= read_pend_d;
    end
  end

  xmpt_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .in_stall_o  (skid_stall),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_out)
  );

  assign action_o        = res_out.action;
  assign mem_address_o   = res_out.mem_address;
  assign wr_word_o       = res_out.wr_word;
  assign status_o        = res_out.status;
  assign fail_address_o  = res_out.fail_address;
  assign expected_word_o = res_out.expected_word;
  assign actual_word_o   = res_out.actual_word;

endmodule

`default_nettype wire

FILE: verif/tb_xorshift_memory_pattern_test.sv
`default_nettype none

module tb_xorshift_memory_pattern_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xmpt_pkg::*;

  localparam int unsigned ADDR_BITS = 32;
  localparam logic [32:0] ADDR_SPACE = 33'd1 << ADDR_BITS;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct {
    opcode_e     op;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] limit;
    logic [31:0] rdata;
    bit          echo;  // returned word is the awaited word xor rdata
  } bist_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  logic        in_valid_i = 1'b0;
  wire         in_stall_o;
  logic [0:0]  opcode_i = '0;
  logic [31:0] base_address_i = '0;
  logic [31:0] byte_size_i = '0;
  logic [31:0] word_limit_i = '0;
  logic [31:0] rd_word_i = '0;

  wire         out_valid_o;
  logic        out_stall_i = 1'b0;
  wire  [1:0]  action_o;
  wire  [31:0] mem_address_o;
  wire  [31:0] wr_word_o;
  wire  [1:0]  status_o;
  wire  [31:0] fail_address_o;
  wire  [31:0] expected_word_o;
  wire  [31:0] actual_word_o;

  xorshift_memory_pattern_test #(
    .ADDR_WIDTH(ADDR_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .base_address_i (base_address_i),
    .byte_size_i    (byte_size_i),
    .word_limit_i   (word_limit_i),
    .rd_word_i      (rd_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .mem_address_o  (mem_address_o),
    .wr_word_o      (wr_word_o),
    .status_o       (status_o),
    .fail_address_o (fail_address_o),
    .expected_word_o(expected_word_o),
    .actual_word_o  (actual_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  bist_cmd_t   cmd_feed[$];
  result_t     bist_outcomes_due[$];
  bist_cmd_t   cmd_on_bus;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predictor copy of the window registers and the sequencer state
  logic [31:0] win_base = '0;
  logic [31:0] win_end = '1;
  phase_e      seq_phase = PH_IDLE;
  logic [31:0] seq_index = '0;
  logic [31:0] seq_count = '0;
  logic [31:0] seq_start = '0;
  logic [31:0] seq_pattern = SEED_WORD;
  logic [31:0] seq_read_expect = '0;
  logic        seq_read_open = 1'b0;

  function automatic logic [31:0] xorshift_advance(logic [31:0] s);
    logic [31:0] v;
    v = s ^ (s << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  function automatic result_t predict_bist_outcome(bist_cmd_t c);
    result_t     r;
    logic [32:0] span_end;
    r = '0;
    r.action = ACT_IDLE;
    r.status = ST_OK;
    span_end = {1'b0, c.base} + {1'b0, c.size};
    if (c.op == OP_START) begin
      seq_read_open = 1'b0;
      seq_read_expect = '0;
      if (c.base < win_base || c.base[1:0] != 2'b00 || c.size < 32'd4 || c.limit == '0
          || span_end > {1'b0, win_end} + 33'd1 || span_end > ADDR_SPACE) begin
        seq_phase = PH_IDLE;
        r.action = ACT_FINISH;
        r.status = ST_INVALID;
      end else begin
        seq_count = ((c.size >> 2) < c.limit) ? (c.size >> 2) : c.limit;
        seq_start = c.base;
        seq_index = '0;
        seq_pattern = SEED_WORD;
        seq_phase = PH_WRITE;
      end
    end else if (seq_phase == PH_WRITE) begin
      r.action = ACT_WRITE;
      r.mem_address = seq_start + (seq_index << 2);
      seq_pattern = xorshift_advance(seq_pattern);
      r.wr_word = seq_pattern;
      seq_index++;
      if (seq_index >= seq_count) begin
        seq_phase = PH_READ;
        seq_index = '0;
        seq_pattern = SEED_WORD;
        seq_read_open = 1'b0;
      end
    end else if (seq_phase == PH_READ) begin
      // check the word asked for by the previous step before issuing the next read
      if (seq_read_open) begin
        seq_read_open = 1'b0;
        if (c.rdata != seq_read_expect) begin
          seq_phase = PH_IDLE;
          r.action = ACT_FINISH;
          r.status = ST_MISMATCH;
          r.fail_address = seq_start + (seq_index << 2);
          r.expected_word = seq_read_expect;
          r.actual_word = c.rdata;
          return r;
        end
        seq_index++;
        if (seq_index >= seq_count) begin
          seq_phase = PH_IDLE;
          r.action = ACT_FINISH;
          return r;
        end
      end
      seq_pattern = xorshift_advance(seq_pattern);
      seq_read_expect = seq_pattern;
      seq_read_open = 1'b1;
      r.action = ACT_READ;
      r.mem_address = seq_start + (seq_index << 2);
    end else begin
      seq_phase = PH_IDLE;
    end
    return r;
  endfunction

  // Input driver: hold a transfer until it is taken, then load the next one
  always @(posedge clk_i) begin : drive_cmds
    logic      took;
    bist_cmd_t c;
    took = in_valid_i && !in_stall_o;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (took) begin
        bist_outcomes_due.push_back(predict_bist_outcome(cmd_on_bus));
      end
      if (!in_valid_i || took) begin
        if (cmd_feed.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          c = cmd_feed.pop_front();
          if (c.echo) begin
            c.rdata = seq_read_expect ^ c.rdata;
            c.echo = 1'b0;
          end
          cmd_on_bus = c;
          in_valid_i <= 1'b1;
          opcode_i <= c.op;
          base_address_i <= c.base;
          byte_size_i <= c.size;
          word_limit_i <= c.limit;
          rd_word_i <= c.rdata;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bist_outcomes_due.size() == 0) begin
        $display("%0t: result with none awaited: expected nothing, got action %0d",
                 $time, action_o);
        mismatches++;
      end else begin
        want = bist_outcomes_due.pop_front();
        check_field("action", 32'(want.action), 32'(action_o));
        check_field("mem_address", want.mem_address, mem_address_o);
        check_field("wr_word", want.wr_word, wr_word_o);
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("fail_address", want.fail_address, fail_address_o);
        check_field("expected_word", want.expected_word, expected_word_o);
        check_field("actual_word", want.actual_word, actual_word_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb_xorshift_memory_pattern_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_window_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WINDOW_BASE) win_base = value;
    else win_end = value;
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (cmd_feed.size() != 0 || in_valid_i || bist_outcomes_due.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic queue_start(logic [31:0] base, logic [31:0] size, logic [31:0] limit);
    bist_cmd_t c;
    c.op = OP_START;
    c.base = base;
    c.size = size;
    c.limit = limit;
    c.rdata = $urandom;
    c.echo = 1'b0;
    cmd_feed.push_back(c);
  endtask

  task automatic queue_step(logic [31:0] rdata, bit echo);
    bist_cmd_t c;
    c.op = OP_STEP;
    c.base = $urandom;
    c.size = $urandom;
    c.limit = $urandom;
    c.rdata = rdata;
    c.echo = echo;
    cmd_feed.push_back(c);
  endtask

  // Odd starts and stray steps, biased towards the window edges
  task automatic queue_noise();
    bist_cmd_t c;
    c.op = opcode_e'($urandom_range(0, 1));
    c.base = $urandom;
    c.size = $urandom;
    c.limit = $urandom;
    c.rdata = $urandom;
    c.echo = 1'b0;
    case ($urandom_range(0, 5))
      0: begin
        c.op = OP_START;
        c.base = (win_base - $urandom_range(1, 64)) & ~32'd3;
        c.size = $urandom_range(4, 64);
      end
      1: begin
        c.op = OP_START;
        c.base = (win_end - $urandom_range(0, 16)) & ~32'd3;
        c.size = $urandom_range(8, 64);
      end
      2: begin
        c.op = OP_START;
        c.limit = '0;
      end
      3: begin
        c.op = OP_START;
        c.size = $urandom_range(0, 3);
      end
      default: ;
    endcase
    cmd_feed.push_back(c);
  endtask

  // One window test: start, writes, reads, some bad or cut short, else noise
  task automatic queue_test_run();
    longint unsigned lo, hi, total, off, avail, words, span, limit, eff;
    int unsigned     bad_k, cut, n;
    logic [31:0]     mask;
    lo = (64'(win_base) + 64'd3) & ~64'd3;
    hi = 64'(win_end) + 64'd1;
    if (lo + 64'd4 > hi) begin
      queue_noise();
      return;
    end
    total = (hi - lo) >> 2;
    if ($urandom_range(0, 1) == 0) off = $urandom_range(0, 32'(total - 1));
    else off = $urandom_range(0, (total - 1 < 7) ? 32'(total - 1) : 7);
    avail = total - off;
    words = $urandom_range(1, (avail < 8) ? 32'(avail) : 8);
    span = ($urandom_range(0, 3) == 0) ? ((avail < 4096) ? avail : 4096) : words;
    case ($urandom_range(0, 2))
      0: limit = words;
      1: limit = $urandom;
      default: limit = 64'hFFFF_FFFF;
    endcase
    if (span > words) limit = words;
    eff = (span < limit) ? span : limit;
    queue_start(32'(lo + 4 * off),
                32'(4 * span + ((span < avail) ? $urandom_range(0, 3) : 0)), 32'(limit));
    bad_k = (eff != 0 && $urandom_range(0, 5) == 0) ? $urandom_range(1, 32'(eff)) : 0;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'(2 * eff)) : 32'(2 * eff + 1);
    n = 0;
    for (int unsigned i = 0; i < eff; i++) begin
      if (n < cut) queue_step($urandom, 1'b0);
      n++;
    end
    for (int unsigned k = 0; k <= eff; k++) begin
      mask = $urandom;
      if (mask == '0) mask = 32'd1;
      if (n < cut) begin
        if (k == 0) queue_step($urandom, 1'b0);
        else queue_step((k == bad_k) ? mask : 32'd0, 1'b1);
      end
      n++;
    end
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned target;
    target = cmd_feed.size() + count;
    while (cmd_feed.size() < target) begin
      if ($urandom_range(0, 4) == 0) queue_noise();
      else queue_test_run();
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_gap_pct = 37;
    recv_stall_pct = 60;

    queue_step(32'hFFFF_FFFF, 1'b0);
    queue_start(32'h0, 32'h0, 32'd1);
    queue_start(32'h2, 32'd16, 32'd4);
    queue_start(32'h0, 32'd16, 32'h0);
    queue_start(32'hFFFF_FFFC, 32'd8, 32'd1);
    queue_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_start(32'hFFFF_FFFC, 32'd4, 32'hFFFF_FFFF);
    queue_step(32'hFFFF_FFFF, 1'b0);
    queue_step(32'h0, 1'b0);
    queue_step(32'h0, 1'b1);
    // whole address space with the word limit capping the count, then a bad read
    queue_start(32'h0, 32'hFFFF_FFFF, 32'd2);
    queue_step(32'h0, 1'b0);
    queue_step(32'h0, 1'b0);
    queue_step(32'hAAAA_5555, 1'b0);
    queue_step(32'h0, 1'b1);
    queue_step(32'h8000_0001, 1'b1);
    // abandon a running test in the read pass, before and after its first read
    queue_start(32'h10, 32'd7, 32'd5);
    queue_step(32'h0, 1'b0);
    queue_start(32'h20, 32'd12, 32'd3);
    queue_step(32'h0, 1'b0);
    queue_step(32'h0, 1'b0);
    queue_step(32'h0, 1'b0);
    queue_step(32'h0, 1'b0);
    queue_start(32'h0, 32'd4, 32'd1);
    queue_step(32'h0, 1'b0);
    queue_step(32'h0, 1'b0);
    queue_step(32'hFFFF_FFFF, 1'b1);
    wait_for_drain();

    write_window_reg(REG_WINDOW_BASE, 32'h0000_1000);
    write_window_reg(REG_WINDOW_END, 32'h0000_1FFF);
    queue_random(450);
    wait_for_drain();

    send_gap_pct = 60;
    recv_stall_pct = 37;
    write_window_reg(REG_WINDOW_BASE, 32'hFFFF_FF00);
    write_window_reg(REG_WINDOW_END, 32'hFFFF_FFFF);
    queue_random(450);
    wait_for_drain();

    write_window_reg(REG_WINDOW_BASE, 32'h0);
    write_window_reg(REG_WINDOW_END, 32'h3F);
    queue_random(120);
    wait_for_drain();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    // empty window: nothing may start
    write_window_reg(REG_WINDOW_BASE, 32'hFFFF_FFFF);
    write_window_reg(REG_WINDOW_END, 32'h0);
    queue_random(30);
    wait_for_drain();

    write_window_reg(REG_WINDOW_BASE, 32'h0);
    write_window_reg(REG_WINDOW_END, 32'hFFFF_FFFF);
    queue_random(400);
    wait_for_drain();

    if (mismatches == 0) begin
      $display("tb_xorshift_memory_pattern_test: clean");
    end else begin
      $display("tb_xorshift_memory_pattern_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/xmpt_pkg.sv
rtl/core/xmpt_skid.sv
rtl/core/xorshift_memory_pattern_test.sv
verif/tb_xorshift_memory_pattern_test.sv
